// File: hw/rtl/sbis_pkg.sv
// ----------------------------------------------------------------------------
// sbis_pkg
// Shared widths, default sizes and the command/status bundles that pass
// between the sparse bit set controller and its datapath.
// ----------------------------------------------------------------------------
package sbis_pkg;

	localparam int WORD_BITS          = 64;
	localparam int BIT_IDX_W          = 16;
	localparam int POS_W              = 10;
	localparam int BIT_SEL_W          = 6;
	localparam int SLOT_OUT_W         = 8;
	localparam int DEF_WORD_POSITIONS = 1024;
	localparam int DEF_STORE_SLOTS    = 256;

	// Operation codes of an input beat
	localparam logic OP_SET_BIT = 1'b0;
	localparam logic OP_OR_WORD = 1'b1;

	typedef struct packed {
		logic clear;          // zero one map entry and advance the sweep
		logic accept;         // capture the input beat and read the map
		logic store_rd;       // read the store at the mapped slot
		logic commit_lookup;  // finish an item that needs no store read
		logic commit_merge;   // write back the merged word and finish
	} sbis_cmd_t;

	typedef struct packed {
		logic clear_last;     // sweep is at the last map entry
		logic hit;            // addressed position already owns a slot
		logic out_free;       // output register can take a result now
	} sbis_status_t;

endpackage

// File: hw/rtl/sbis_ram.sv
// ----------------------------------------------------------------------------
// sbis_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/sbis_ctrl.sv
// ----------------------------------------------------------------------------
// sbis_ctrl
// Sequencer for the sparse bit set: map clearing sweep after reset, then
// accept, map lookup, optional store read-modify-write, and result commit.
// ----------------------------------------------------------------------------
module sbis_ctrl
	import sbis_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  sbis_status_t status,
	output sbis_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_MERGE
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_LOOKUP: begin
				if (status.hit) begin
					cmd.store_rd = 1'b1;
				end else begin
					cmd.commit_lookup = status.out_free;
				end
			end
			ST_MERGE: begin
				cmd.commit_merge = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (status.hit) begin
						state_q <= ST_MERGE;
					end else if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MERGE: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.accept, cmd.store_rd, cmd.commit_lookup, cmd.commit_merge}))
		else $error("controller issued more than one command");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second beat accepted while an item is in flight");

	a_merge_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MERGE && status.out_free) |=> (state_q == ST_IDLE))
		else $error("merge did not finish once the output was free");
`endif

endmodule

// File: hw/rtl/sbis_dp.sv
// ----------------------------------------------------------------------------
// sbis_dp
// Datapath of the sparse bit set: word map and word store RAMs, clearing
// sweep counter, slot allocator, group flag and the output register.
// ----------------------------------------------------------------------------
module sbis_dp
	import sbis_pkg::*;
#(
	parameter int WORD_POSITIONS = DEF_WORD_POSITIONS,
	parameter int STORE_SLOTS    = DEF_STORE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbis_cmd_t             cmd,
	output sbis_status_t          status,
	input  logic                  operation,
	input  logic [BIT_IDX_W-1:0]  bit_index,
	input  logic [POS_W-1:0]      word_index,
	input  logic [WORD_BITS-1:0]  word_value,
	input  logic                  group_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  changed,
	output logic [WORD_BITS-1:0]  word_now,
	output logic [SLOT_OUT_W-1:0] slot_used,
	output logic                  store_full,
	output logic                  group_changed
);

	localparam int MAP_AW = (WORD_POSITIONS > 1) ? $clog2(WORD_POSITIONS) : 1;
	localparam int SLOT_W = $clog2(STORE_SLOTS);
	localparam int NFS_W  = SLOT_W + 1;
	localparam int PEXT_W = POS_W + MAP_AW;
	localparam logic [PEXT_W-1:0] POS_LIMIT  = PEXT_W'(WORD_POSITIONS);
	localparam logic [MAP_AW-1:0] CLEAR_LAST = MAP_AW'(WORD_POSITIONS - 1);
	localparam logic [NFS_W-1:0]  SLOT_LIMIT = NFS_W'(STORE_SLOTS);

	// Decode of the incoming beat
	logic [POS_W-1:0]     pos_d;
	logic [WORD_BITS-1:0] val_d;
	logic [PEXT_W-1:0]    pos_ext;
	logic [MAP_AW-1:0]    addr_d;
	logic                 inr_d;

	// Captured item
	logic [MAP_AW-1:0]    addr_q;
	logic [WORD_BITS-1:0] val_q;
	logic                 inr_q;
	logic                 last_q;

	// Control state
	logic [MAP_AW-1:0]    clr_q;
	logic [NFS_W-1:0]     nfs_q;
	logic                 sticky_q;

	// RAM interfaces
	logic                 map_we;
	logic [MAP_AW-1:0]    map_waddr;
	logic [SLOT_W-1:0]    map_wdata;
	logic [SLOT_W-1:0]    cur;
	logic                 st_we;
	logic [SLOT_W-1:0]    st_waddr;
	logic [WORD_BITS-1:0] st_wdata;
	logic [WORD_BITS-1:0] old_word;

	// Lookup decisions
	logic                 cur_zero;
	logic                 has_free;
	logic                 need_slot;
	logic                 alloc;
	logic                 full;
	logic [WORD_BITS-1:0] merged;
	logic                 merge_chg;

	// Result selection
	logic                 commit;
	logic                 res_chg;
	logic [WORD_BITS-1:0] res_word;
	logic [SLOT_W-1:0]    res_slot;
	logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;
	logic                 res_full;
	logic                 res_gchg;

	logic                 out_valid_q;
	logic                 changed_q;
	logic [WORD_BITS-1:0] word_now_q;
	logic [SLOT_OUT_W-1:0] slot_used_q;
	logic                 store_full_q;
	logic                 group_changed_q;

	always_comb begin
		if (operation == OP_SET_BIT) begin
			pos_d = bit_index[BIT_IDX_W-1:BIT_SEL_W];
			val_d = WORD_BITS'(1) << bit_index[BIT_SEL_W-1:0];
		end else begin
			pos_d = word_index;
			val_d = word_value;
		end
	end

	assign pos_ext = {{MAP_AW{1'b0}}, pos_d};
	assign addr_d  = pos_ext[MAP_AW-1:0];
	assign inr_d   = (pos_ext < POS_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= addr_d;
			val_q  <= val_d;
			inr_q  <= inr_d;
			last_q <= group_last;
		end
	end

	// Map: sweep writes zero after reset, allocation writes the new slot
	assign map_we    = cmd.clear || (cmd.commit_lookup && alloc);
	assign map_waddr = cmd.clear ? clr_q : addr_q;
	assign map_wdata = cmd.clear ? '0 : nfs_q[SLOT_W-1:0];

	sbis_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (WORD_POSITIONS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (cmd.accept),
		.raddr (addr_d),
		.rdata (cur)
	);

	assign cur_zero  = (cur == '0);
	assign has_free  = (nfs_q < SLOT_LIMIT);
	assign need_slot = inr_q && cur_zero && (val_q != '0);
	assign alloc     = need_slot && has_free;
	assign full      = need_slot && !has_free;
	assign merged    = old_word | val_q;
	assign merge_chg = (merged != old_word);

	assign status.hit        = inr_q && !cur_zero && ({1'b0, cur} < SLOT_LIMIT);
	assign status.clear_last = (clr_q == CLEAR_LAST);
	assign status.out_free   = !out_valid_q || !out_stall;

	assign st_we    = cmd.commit_merge || (cmd.commit_lookup && alloc);
	assign st_waddr = cmd.commit_merge ? cur : nfs_q[SLOT_W-1:0];
	assign st_wdata = cmd.commit_merge ? merged : val_q;

	sbis_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STORE_SLOTS)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.store_rd),
		.raddr (cur),
		.rdata (old_word)
	);

	assign commit = cmd.commit_lookup || cmd.commit_merge;

	always_comb begin
		if (cmd.commit_merge) begin
			res_chg  = merge_chg;
			res_word = merged;
			res_slot = cur;
			res_full = 1'b0;
		end else begin
			res_chg  = alloc;
			res_word = alloc ? val_q : '0;
			res_slot = alloc ? nfs_q[SLOT_W-1:0] : '0;
			res_full = full;
		end
	end

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot};
	assign res_gchg = sticky_q || res_chg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			nfs_q       <= NFS_W'(1);
			sticky_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + MAP_AW'(1);
			end
			if (cmd.commit_lookup && alloc) begin
				nfs_q <= nfs_q + NFS_W'(1);
			end
			if (commit) begin
				sticky_q    <= last_q ? 1'b0 : res_gchg;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			changed_q       <= res_chg;
			word_now_q      <= res_word;
			slot_used_q     <= slot_ext[SLOT_OUT_W-1:0];
			store_full_q    <= res_full;
			group_changed_q <= res_gchg;
		end
	end

	assign out_valid     = out_valid_q;
	assign changed       = changed_q;
	assign word_now      = word_now_q;
	assign slot_used     = slot_used_q;
	assign store_full    = store_full_q;
	assign group_changed = group_changed_q;

`ifndef SYNTH
	a_nfs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfs_q <= SLOT_LIMIT)
		else $error("free slot pointer ran past the store");

	a_merge_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_merge |-> !cur_zero)
		else $error("merge write-back to the reserved slot");

	a_sticky_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && last_q) |=> !sticky_q)
		else $error("group flag survived the last beat of a group");
`endif

endmodule

// File: hw/rtl/sparse_bitset_indirect_store.sv
// ----------------------------------------------------------------------------
// sparse_bitset_indirect_store
// Sparse bit set: a word map points each 64-bit word position at a slot of
// a compact word store; items set one bit or OR in a whole word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one item per beat: a single-bit
// set at bit_index, or an OR of word_value at word_index. Output channel
// (out_valid/out_stall) returns one result beat per item: changed, the word
// after the update, its slot, store_full and the running group flag.
// After reset the block sweeps the word map to zero, one entry a cycle;
// in_stall stays high during the sweep. Items are worked one at a time.
// The accept cycle reads the map; the lookup state that follows either
// finishes the item (empty position, allocation, out of range, store full)
// once the output register is free, or reads the store; a merge then
// finishes in the merge state with the write-back, again once the output
// register is free. The next item is accepted only after the commit, when
// the controller is back in idle; an item's work is the map read followed,
// for an occupied word, by the store read-modify-write.
// A finished result waits in the output register while the next item is
// accepted and looked up; a stalled receiver holds the item at commit.
// ----------------------------------------------------------------------------
module sparse_bitset_indirect_store
	import sbis_pkg::*;
#(
	parameter int WORD_POSITIONS = DEF_WORD_POSITIONS,
	parameter int STORE_SLOTS    = DEF_STORE_SLOTS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  operation,
	input  logic [BIT_IDX_W-1:0]  bit_index,
	input  logic [POS_W-1:0]      word_index,
	input  logic [WORD_BITS-1:0]  word_value,
	input  logic                  group_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  changed,
	output logic [WORD_BITS-1:0]  word_now,
	output logic [SLOT_OUT_W-1:0] slot_used,
	output logic                  store_full,
	output logic                  group_changed
);

	sbis_cmd_t    cmd;
	sbis_status_t status;

	sbis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sbis_dp #(
		.WORD_POSITIONS (WORD_POSITIONS),
		.STORE_SLOTS    (STORE_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (operation),
		.bit_index     (bit_index),
		.word_index    (word_index),
		.word_value    (word_value),
		.group_last    (group_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.changed       (changed),
		.word_now      (word_now),
		.slot_used     (slot_used),
		.store_full    (store_full),
		.group_changed (group_changed)
	);

endmodule

// File: dv/tb_sparse_bitset_indirect_store.sv
// ----------------------------------------------------------------------------
// tb_sparse_bitset_indirect_store
// Self-checking bench for the sparse bit set. A directed opening covers the
// corner words and bits, then random beats merge into a working set of
// positions until the word store runs out of slots. A shadow map and store
// predict every result beat, and the monitor compares each one in order.
// ----------------------------------------------------------------------------
module tb_sparse_bitset_indirect_store;
	import sbis_pkg::*;

	localparam int RANDOM_BEATS = 1250;
	localparam int QUIET_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_AT      = 350;

	typedef struct {
		logic                 op;
		logic [BIT_IDX_W-1:0] bit_index;
		logic [POS_W-1:0]     word_index;
		logic [WORD_BITS-1:0] word_value;
		logic                 last;
		int unsigned          gap;
	} set_beat_t;

	typedef struct {
		logic                  changed;
		logic [WORD_BITS-1:0]  word_now;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  full;
		logic                  group_changed;
	} set_result_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_stall;
	logic                  operation     = OP_SET_BIT;
	logic [BIT_IDX_W-1:0]  bit_index     = '0;
	logic [POS_W-1:0]      word_index    = '0;
	logic [WORD_BITS-1:0]  word_value    = '0;
	logic                  group_last    = 1'b0;
	logic                  out_valid;
	logic                  out_stall     = 1'b0;
	logic                  changed;
	logic [WORD_BITS-1:0]  word_now;
	logic [SLOT_OUT_W-1:0] slot_used;
	logic                  store_full;
	logic                  group_changed;

	// shadow of the block
	int unsigned          word_slot [DEF_WORD_POSITIONS];
	logic [WORD_BITS-1:0] slot_word [DEF_STORE_SLOTS];
	int unsigned          next_slot;
	logic                 group_sticky;
	int unsigned          used_pos [$];

	set_beat_t   pending_beats [$];
	set_result_t expected_updates [$];
	set_beat_t   cur_beat;

	int unsigned total_beats = 0;
	int unsigned beats_in    = 0;
	int unsigned beats_out   = 0;
	int unsigned fails       = 0;
	int unsigned n_alloc     = 0;
	int unsigned n_full      = 0;
	int unsigned n_idle_or   = 0;
	int unsigned in_wait     = 0;
	int unsigned idle_run;
	int unsigned stall_left  = 0;
	int unsigned hold_left   = 0;
	logic        hold_req    = 1'b0;
	logic        hold_done   = 1'b0;

	sparse_bitset_indirect_store u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.bit_index    (bit_index),
		.word_index   (word_index),
		.word_value   (word_value),
		.group_last   (group_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.changed      (changed),
		.word_now     (word_now),
		.slot_used    (slot_used),
		.store_full   (store_full),
		.group_changed(group_changed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void predict_update(input set_beat_t b);
		int unsigned          pos;
		int unsigned          slot;
		logic [WORD_BITS-1:0] val;
		logic [WORD_BITS-1:0] merged;
		set_result_t          r;
		r = '{changed: 1'b0, word_now: '0, slot: '0, full: 1'b0, group_changed: 1'b0};
		if (b.op == OP_SET_BIT) begin
			pos = 32'(b.bit_index >> BIT_SEL_W);
			val = 64'd1 << b.bit_index[BIT_SEL_W-1:0];
		end else begin
			pos = 32'(b.word_index);
			val = b.word_value;
		end
		if (pos < DEF_WORD_POSITIONS) begin
			slot = word_slot[pos];
			if (slot != 0) begin
				merged = slot_word[slot] | val;
				r.changed = (merged != slot_word[slot]);
				slot_word[slot] = merged;
				r.word_now = merged;
				r.slot = slot[SLOT_OUT_W-1:0];
				if (!r.changed)
					n_idle_or++;
			end else if (val != '0) begin
				if (next_slot < DEF_STORE_SLOTS) begin
					word_slot[pos] = next_slot;
					slot_word[next_slot] = val;
					r.slot = next_slot[SLOT_OUT_W-1:0];
					r.word_now = val;
					r.changed = 1'b1;
					next_slot++;
					used_pos = {used_pos, pos};
					n_alloc++;
				end else begin
					r.full = 1'b1;
					n_full++;
				end
			end
		end
		r.group_changed = group_sticky | r.changed;
		group_sticky = b.last ? 1'b0 : r.group_changed;
		expected_updates = {expected_updates, r};
	endfunction

	function automatic void check_update();
		set_result_t e;
		if (expected_updates.size() == 0) begin
			$error("result beat with no expectation waiting");
			fails++;
			return;
		end
		e = expected_updates.pop_front();
		if (changed !== e.changed) begin
			$error("changed: expected %0d, got %0d", e.changed, changed);
			fails++;
		end
		if (word_now !== e.word_now) begin
			$error("word_now: expected %h, got %h", e.word_now, word_now);
			fails++;
		end
		if (slot_used !== e.slot) begin
			$error("slot_used: expected %0d, got %0d", e.slot, slot_used);
			fails++;
		end
		if (store_full !== e.full) begin
			$error("store_full: expected %0d, got %0d", e.full, store_full);
			fails++;
		end
		if (group_changed !== e.group_changed) begin
			$error("group_changed: expected %0d, got %0d", e.group_changed, group_changed);
			fails++;
		end
	endfunction

	function automatic int unsigned draw_pause(input logic calm);
		if (calm || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	task automatic queue_beat(input logic op, input logic [BIT_IDX_W-1:0] bidx,
			input logic [POS_W-1:0] widx, input logic [WORD_BITS-1:0] wval,
			input logic last, input logic calm);
		set_beat_t b;
		b.op         = op;
		b.bit_index  = bidx;
		b.word_index = widx;
		b.word_value = wval;
		b.last       = last;
		b.gap        = draw_pause(calm);
		pending_beats = {pending_beats, b};
		total_beats++;
	endtask

	// driver: predict each beat as it is accepted, then load the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			operation  <= OP_SET_BIT;
			bit_index  <= '0;
			word_index <= '0;
			word_value <= '0;
			group_last <= 1'b0;
			in_wait    <= 0;
		end else if (!in_valid || !in_stall) begin
			idle_run = in_valid ? 0 : in_wait;
			if (in_valid) begin
				predict_update(cur_beat);
				beats_in++;
			end
			if (pending_beats.size() != 0 && idle_run >= pending_beats[0].gap) begin
				cur_beat = pending_beats.pop_front();
				in_valid   <= 1'b1;
				operation  <= cur_beat.op;
				bit_index  <= cur_beat.bit_index;
				word_index <= cur_beat.word_index;
				word_value <= cur_beat.word_value;
				group_last <= cur_beat.last;
				in_wait    <= 0;
			end else begin
				in_valid <= 1'b0;
				in_wait  <= idle_run + 1;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_update();
				beats_out++;
				stall_left = draw_pause((beats_out % 170) >= 120);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0) || (hold_left != 0);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_sparse_bitset_indirect_store: FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned          pos;
		int unsigned          kind;
		logic                 op;
		logic                 calm;
		logic [WORD_BITS-1:0] val;
		for (int p = 0; p < DEF_WORD_POSITIONS; p++)
			word_slot[p] = 0;
		for (int s = 0; s < DEF_STORE_SLOTS; s++)
			slot_word[s] = '0;
		next_slot    = 1;
		group_sticky = 1'b0;

		// corners: first and last bit, zero words, no-change merges, full words
		queue_beat(OP_SET_BIT, 16'd0, POS_W'($urandom), {$urandom, $urandom}, 1'b0, 1'b0);
		queue_beat(OP_SET_BIT, 16'd63, POS_W'($urandom), {$urandom, $urandom}, 1'b0, 1'b0);
		queue_beat(OP_SET_BIT, 16'd0, POS_W'($urandom), {$urandom, $urandom}, 1'b1, 1'b0);
		queue_beat(OP_SET_BIT, 16'hFFFF, POS_W'($urandom), {$urandom, $urandom}, 1'b0, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'h3FF, '1, 1'b0, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'h3FF, '0, 1'b1, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd500, '0, 1'b1, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd0, 64'h8000_0000_0000_0001,
			1'b1, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd1, 64'hAAAA_AAAA_AAAA_AAAA,
			1'b0, 1'b1);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd1, 64'h5555_5555_5555_5555,
			1'b0, 1'b1);
		queue_beat(OP_SET_BIT, 16'd64, POS_W'($urandom), {$urandom, $urandom}, 1'b0, 1'b1);
		queue_beat(OP_SET_BIT, 16'd127, POS_W'($urandom), {$urandom, $urandom}, 1'b1, 1'b1);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd512, 64'h1, 1'b0, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'd512, 64'h8000_0000_0000_0000,
			1'b0, 1'b0);
		queue_beat(OP_SET_BIT, 16'h8000, POS_W'($urandom), {$urandom, $urandom}, 1'b1, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'h155, 64'hDEAD_BEEF_0123_4567,
			1'b0, 1'b0);
		queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), 10'h2AA, 64'h0123_4567_89AB_CDEF,
			1'b1, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// random: mostly hit live positions, sometimes open a fresh one
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			while (pending_beats.size() >= 4)
				@(posedge clk);
			if (i == HOLD_AT)
				hold_req <= 1'b1;
			calm = (i % 200) >= 150;
			if (used_pos.size() != 0 && $urandom_range(0, 9) < 7)
				pos = used_pos[$urandom_range(0, used_pos.size() - 1)];
			else
				pos = $urandom_range(0, DEF_WORD_POSITIONS - 1);
			op = 1'($urandom_range(0, 1));
			if (op == OP_SET_BIT) begin
				queue_beat(OP_SET_BIT, {pos[POS_W-1:0], 6'($urandom_range(0, 63))},
					POS_W'($urandom), {$urandom, $urandom}, $urandom_range(0, 3) == 0,
					calm);
			end else begin
				kind = $urandom_range(0, 9);
				if (kind == 0)
					val = '0;
				else if (kind <= 2 && word_slot[pos] != 0)
					val = slot_word[word_slot[pos]] & {$urandom, $urandom};
				else if (kind <= 4)
					val = 64'd1 << $urandom_range(0, 63);
				else if (kind == 5)
					val = '1;
				else
					val = {$urandom, $urandom};
				queue_beat(OP_OR_WORD, BIT_IDX_W'($urandom), pos[POS_W-1:0], val,
					$urandom_range(0, 3) == 0, calm);
			end
		end

		while (beats_in != total_beats || expected_updates.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Ran %0d beats: %0d slots allocated, %0d writes dropped on a full store,",
			beats_out, n_alloc, n_full);
		$display("%0d merges into occupied words added no bits.", n_idle_or);
		if (fails == 0)
			$display("tb_sparse_bitset_indirect_store: PASS");
		else
			$display("tb_sparse_bitset_indirect_store: FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/sbis_pkg.sv
hw/rtl/sbis_ram.sv
hw/rtl/sbis_ctrl.sv
hw/rtl/sbis_dp.sv
hw/rtl/sparse_bitset_indirect_store.sv
dv/tb_sparse_bitset_indirect_store.sv
